/* rtl/core/tes_pkg.sv */
// Shared types, constants and parameter reduction functions of the timed event sequencer.
package tes_pkg;

  localparam int PROGRAM_LINES = 16;
  localparam int PC_W = $clog2(PROGRAM_LINES);
  localparam int PARAM_W = 11;

  localparam int BEEP_MOD = 600;
  localparam int WAIT_MOD = 600;
  localparam int DAY_MINUTES = 24 * 60;
  localparam int DAC_MOD = 255;
  localparam int MS_PER_S = 1000;
  localparam int MINUTES_PER_HOUR = 60;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  localparam logic [2:0] OP_NOP         = 3'd0;
  localparam logic [2:0] OP_BEEP        = 3'd1;
  localparam logic [2:0] OP_WAIT_TICKS  = 3'd2;
  localparam logic [2:0] OP_WAIT_TIME   = 3'd3;
  localparam logic [2:0] OP_WAIT_BUTTON = 3'd4;
  localparam logic [2:0] OP_DAC         = 3'd5;
  localparam logic [2:0] OP_RESTART     = 3'd6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  line_index;
    logic [2:0]  line_opcode;
    logic [15:0] line_argument;
    logic [31:0] now_ms;
    logic [4:0]  hour_now;
    logic [5:0]  minute_now;
    logic [3:0]  released_buttons;
  } in_word_t;

  typedef struct packed {
    logic       tone_on;
    logic [7:0] dac_level;
    logic [3:0] current_line;
    logic       running;
    logic       finished;
  } out_word_t;

  typedef struct packed {
    logic            run;
    logic [PC_W-1:0] pc;
    logic [31:0]     scratch;
    logic            tone;
    logic [7:0]      dac;
  } seq_state_t;

  function automatic logic [PARAM_W-1:0] mod_600(input logic [15:0] a);
    logic [15:0] r;
    r = a;
    for (int k = 6; k >= 0; k--) begin
      if (r >= (16'(BEEP_MOD) << k)) begin
        r = r - (16'(BEEP_MOD) << k);
      end
    end
    return PARAM_W'(r);
  endfunction

  function automatic logic [PARAM_W-1:0] mod_1440(input logic [15:0] a);
    logic [15:0] r;
    r = a;
    for (int k = 5; k >= 0; k--) begin
      if (r >= (16'(DAY_MINUTES) << k)) begin
        r = r - (16'(DAY_MINUTES) << k);
      end
    end
    return PARAM_W'(r);
  endfunction

  function automatic logic [7:0] mod_255(input logic [15:0] a);
    logic [8:0] s;
    logic [8:0] t;
    s = {1'b0, a[15:8]} + {1'b0, a[7:0]};
    t = {1'b0, s[7:0]} + 9'(s[8]);
    if (t >= 9'(DAC_MOD)) begin
      t = t - 9'(DAC_MOD);
    end
    return t[7:0];
  endfunction

endpackage

/* rtl/core/tes_if.sv */
// Valid/ready channel interfaces for input and result words.
interface tes_in_if;
  logic              valid;
  logic              ready;
  tes_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tes_out_if;
  logic               valid;
  logic               ready;
  tes_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/tes_store.sv */
// Program line store: reduces the argument on write, reads the line at the program counter.
module tes_store (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [3:0]                   wr_index,
  input  logic [2:0]                   wr_opcode,
  input  logic [15:0]                  wr_argument,
  input  logic [tes_pkg::PC_W-1:0]     rd_index,
  output logic [2:0]                   rd_opcode,
  output logic [tes_pkg::PARAM_W-1:0]  rd_param
);

  logic [2:0]                  op_store    [tes_pkg::PROGRAM_LINES];
  logic [tes_pkg::PARAM_W-1:0] param_store [tes_pkg::PROGRAM_LINES];
  logic [tes_pkg::PARAM_W-1:0] wr_param;
  logic                        wr_in_range;
  logic [tes_pkg::PC_W-1:0]    wr_addr;

  always_comb begin
    case (wr_opcode)
      tes_pkg::OP_BEEP:        wr_param = tes_pkg::mod_600(wr_argument);
      tes_pkg::OP_WAIT_TICKS:  wr_param = tes_pkg::mod_600(wr_argument);
      tes_pkg::OP_WAIT_TIME:   wr_param = tes_pkg::mod_1440(wr_argument);
      tes_pkg::OP_WAIT_BUTTON: wr_param = tes_pkg::PARAM_W'(wr_argument[1:0]);
      tes_pkg::OP_DAC:         wr_param = tes_pkg::PARAM_W'(tes_pkg::mod_255(wr_argument));
      default:                 wr_param = '0;
    endcase
  end

  assign wr_in_range = 32'(wr_index) < 32'(tes_pkg::PROGRAM_LINES);
  assign wr_addr     = tes_pkg::PC_W'(wr_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tes_pkg::PROGRAM_LINES; i++) begin
        op_store[i]    <= '0;
        param_store[i] <= '0;
      end
    end else if (wr_en && wr_in_range) begin
      op_store[wr_addr]    <= wr_opcode;
      param_store[wr_addr] <= wr_param;
    end
  end

  assign rd_opcode = op_store[rd_index];
  assign rd_param  = param_store[rd_index];

endmodule

/* rtl/core/tes_exec.sv */
// Next-state logic: applies one command or executes one program line.
module tes_exec (
  input  tes_pkg::seq_state_t          cur,
  input  logic [1:0]                   cmd,
  input  logic [2:0]                   opcode,
  input  logic [tes_pkg::PARAM_W-1:0]  param,
  input  logic [31:0]                  now_ms,
  input  logic [4:0]                   hour_now,
  input  logic [5:0]                   minute_now,
  input  logic [3:0]                   released_buttons,
  output tes_pkg::seq_state_t          nxt,
  output logic                         finished
);

  localparam logic [tes_pkg::PC_W-1:0] LAST_LINE = tes_pkg::PC_W'(tes_pkg::PROGRAM_LINES - 1);

  logic [31:0] beep_limit;
  logic [31:0] elapsed;
  logic [11:0] day_minute;
  logic        time_match;
  logic        done;

  assign beep_limit = 32'(param) * 32'(tes_pkg::MS_PER_S);
  assign elapsed    = now_ms - cur.scratch;
  assign day_minute = ({1'b0, hour_now, 6'b0} - {5'b0, hour_now, 2'b0}) + 12'(minute_now);
  assign time_match = (minute_now < 6'(tes_pkg::MINUTES_PER_HOUR))
                      && (day_minute == 12'(param));

  always_comb begin
    nxt      = cur;
    finished = 1'b0;
    done     = 1'b0;
    case (cmd)
      tes_pkg::CMD_START: begin
        nxt.run     = 1'b1;
        nxt.pc      = '0;
        nxt.scratch = '0;
        nxt.tone    = 1'b0;
      end
      tes_pkg::CMD_STOP: begin
        nxt.run  = 1'b0;
        nxt.tone = 1'b0;
      end
      tes_pkg::CMD_TICK: begin
        if (cur.run) begin
          case (opcode)
            tes_pkg::OP_BEEP: begin
              if (cur.scratch == '0) begin
                nxt.scratch = now_ms;
                nxt.tone    = 1'b1;
              end else if (elapsed > beep_limit) begin
                nxt.tone = 1'b0;
                done     = 1'b1;
              end
            end
            tes_pkg::OP_WAIT_TICKS: begin
              if (cur.scratch >= 32'(param)) begin
                done = 1'b1;
              end else begin
                nxt.scratch = cur.scratch + 32'd1;
              end
            end
            tes_pkg::OP_WAIT_TIME:   done = time_match;
            tes_pkg::OP_WAIT_BUTTON: done = released_buttons[param[1:0]];
            tes_pkg::OP_DAC: begin
              nxt.dac = param[7:0];
              done    = 1'b1;
            end
            tes_pkg::OP_RESTART:     nxt.pc = '0;
            default:                 done = 1'b1;
          endcase
          if (done) begin
            nxt.scratch = '0;
            if (cur.pc == LAST_LINE) begin
              nxt.pc   = '0;
              nxt.run  = 1'b0;
              nxt.tone = 1'b0;
              finished = 1'b1;
            end else begin
              nxt.pc = cur.pc + tes_pkg::PC_W'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/timed_event_sequencer_unit.sv */
// Timed event sequencer top level: input register, line store, next-state logic, result register.
// Path: an accepted word is held in the input register, and its result word is then written to the result register.
// Throughput: one word per cycle while result.ready holds; the input register refills while the result register drains.
// The limit is the single pass from the input register through line execution to the result.
// Reset clears the program store, counters, run, tone and DAC value, and both valid flags.
module timed_event_sequencer_unit (
  input logic      clk,
  input logic      rst,
  tes_in_if.sink   item,
  tes_out_if.source result
);

  tes_pkg::in_word_t           item_q;
  logic                        item_v;
  tes_pkg::out_word_t          out_q;
  logic                        out_v;
  tes_pkg::seq_state_t         seq;
  tes_pkg::seq_state_t         seq_next;
  logic                        fin;
  logic                        advance;
  logic [2:0]                  line_op;
  logic [tes_pkg::PARAM_W-1:0] line_param;

  assign advance    = item_v && (!out_v || result.ready);
  assign item.ready = !item_v || !out_v || result.ready;

  tes_store u_store (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (advance && (item_q.cmd == tes_pkg::CMD_WRITE)),
    .wr_index    (item_q.line_index),
    .wr_opcode   (item_q.line_opcode),
    .wr_argument (item_q.line_argument),
    .rd_index    (seq.pc),
    .rd_opcode   (line_op),
    .rd_param    (line_param)
  );

  tes_exec u_exec (
    .cur              (seq),
    .cmd              (item_q.cmd),
    .opcode           (line_op),
    .param            (line_param),
    .now_ms           (item_q.now_ms),
    .hour_now         (item_q.hour_now),
    .minute_now       (item_q.minute_now),
    .released_buttons (item_q.released_buttons),
    .nxt              (seq_next),
    .finished         (fin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
      out_v  <= 1'b0;
      seq    <= '0;
    end else begin
      if (item.valid && item.ready) begin
        item_v <= 1'b1;
      end else if (advance) begin
        item_v <= 1'b0;
      end
      if (advance) begin
        out_v <= 1'b1;
        seq   <= seq_next;
      end else if (result.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_q <= item.data;
    end
    if (advance) begin
      out_q.tone_on      <= seq_next.tone;
      out_q.dac_level    <= seq_next.dac;
      out_q.current_line <= 4'(seq_next.pc);
      out_q.running      <= seq_next.run;
      out_q.finished     <= fin;
    end
  end

  assign result.valid = out_v;
  assign result.data  = out_q;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the timed event sequencer: directed table, random programs, scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tes_pkg::*;

  localparam logic [2:0] OP_SPARE = 3'd7;

  typedef struct {
    in_word_t  stim;
    bit        pinned;
    out_word_t want;
  } drill_row_t;

  logic clk;
  logic rst;

  tes_in_if  item_ch ();
  tes_out_if result_ch ();

  timed_event_sequencer_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  bit [2:0]        op_mem  [PROGRAM_LINES];
  bit [15:0]       arg_mem [PROGRAM_LINES];
  bit [PC_W-1:0]   pc_q;
  bit              run_q;
  bit              tone_q;
  bit [31:0]       scratch_q;
  bit [7:0]        dac_q;

  logic [31:0]     wall_ms;
  out_word_t       pending_status [$];
  drill_row_t      drill [$];
  int              src_idle_pct;
  int              snk_idle_pct;
  int              words_sent;
  int              results_seen;
  int              runs_finished;
  int              errors;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic advance_sequencer(input in_word_t w, output out_word_t st);
    bit [PC_W-1:0] line;
    bit [2:0]      op;
    bit [15:0]     arg;
    int unsigned   span;
    bit [31:0]     elapsed;
    bit            done;
    bit            fin;
    done = 1'b0;
    fin  = 1'b0;
    case (w.cmd)
      CMD_WRITE: begin
        op_mem[w.line_index]  = w.line_opcode;
        arg_mem[w.line_index] = w.line_argument;
      end
      CMD_START: begin
        run_q     = 1'b1;
        pc_q      = '0;
        scratch_q = '0;
        tone_q    = 1'b0;
      end
      CMD_STOP: begin
        run_q  = 1'b0;
        tone_q = 1'b0;
      end
      default: begin
        if (run_q) begin
          line = pc_q;
          op   = op_mem[line];
          arg  = arg_mem[line];
          case (op)
            OP_BEEP: begin
              span = arg % BEEP_MOD;
              elapsed = w.now_ms - scratch_q;
              if (scratch_q == 0) begin
                scratch_q = w.now_ms;
                tone_q    = 1'b1;
              end else if (elapsed > span * MS_PER_S) begin
                tone_q = 1'b0;
                done   = 1'b1;
              end
            end
            OP_WAIT_TICKS: begin
              span = arg % WAIT_MOD;
              if (scratch_q >= span) done = 1'b1;
              else scratch_q = scratch_q + 1;
            end
            OP_WAIT_TIME: begin
              span = arg % DAY_MINUTES;
              done = (w.hour_now == span / MINUTES_PER_HOUR) &&
                     (w.minute_now == span % MINUTES_PER_HOUR);
            end
            OP_WAIT_BUTTON: done = w.released_buttons[arg[1:0]];
            OP_DAC: begin
              dac_q = 8'(arg % DAC_MOD);
              done  = 1'b1;
            end
            OP_RESTART: pc_q = '0;
            default: done = 1'b1;
          endcase
          if (done) begin
            scratch_q = '0;
            if (line == PROGRAM_LINES - 1) begin
              pc_q   = '0;
              run_q  = 1'b0;
              tone_q = 1'b0;
              fin    = 1'b1;
            end else begin
              pc_q = line + 1'b1;
            end
          end
        end
      end
    endcase
    st = '{tone_on: tone_q, dac_level: dac_q, current_line: 4'(pc_q),
           running: run_q, finished: fin};
  endtask

  function automatic in_word_t pack_word(logic [1:0] c, logic [3:0] idx, logic [2:0] op,
                                         logic [15:0] arg, logic [31:0] now,
                                         logic [4:0] hr, logic [5:0] mn, logic [3:0] btn);
    return '{c, idx, op, arg, now, hr, mn, btn};
  endfunction

  function automatic in_word_t rand_word();
    return pack_word(2'($urandom_range(3)), 4'($urandom_range(15)), 3'($urandom_range(7)),
                     16'($urandom_range(65535)), $urandom, 5'($urandom_range(23)),
                     6'($urandom_range(59)), 4'($urandom_range(15)));
  endfunction

  function automatic in_word_t cmd_word(logic [1:0] c);
    in_word_t w;
    w = rand_word();
    w.cmd = c;
    return w;
  endfunction

  function automatic logic [2:0] pick_opcode();
    case ($urandom_range(14))
      0, 1, 2: return OP_NOP;
      3, 4:    return OP_BEEP;
      5, 6:    return OP_WAIT_TICKS;
      7, 8:    return OP_WAIT_TIME;
      9, 10:   return OP_WAIT_BUTTON;
      11, 12:  return OP_DAC;
      13:      return OP_RESTART;
      default: return OP_SPARE;
    endcase
  endfunction

  function automatic in_word_t line_word();
    in_word_t w;
    w = cmd_word(CMD_WRITE);
    w.line_opcode = pick_opcode();
    if ($urandom_range(7) != 0) begin
      if (w.line_opcode == OP_BEEP) begin
        w.line_argument = 16'($urandom_range(2) + BEEP_MOD * $urandom_range(108));
      end else if (w.line_opcode == OP_WAIT_TICKS) begin
        w.line_argument = 16'($urandom_range(5) + WAIT_MOD * $urandom_range(108));
      end
    end
    return w;
  endfunction

  function automatic in_word_t tick_word();
    in_word_t    w;
    int unsigned target;
    w = cmd_word(CMD_TICK);
    if ($urandom_range(9) == 0) wall_ms = $urandom;
    else wall_ms = wall_ms + $urandom_range(1500);
    w.now_ms = wall_ms;
    if (run_q && op_mem[pc_q] == OP_WAIT_TIME && $urandom_range(1) == 1) begin
      target       = arg_mem[pc_q] % DAY_MINUTES;
      w.hour_now   = 5'(target / MINUTES_PER_HOUR);
      w.minute_now = 6'(target % MINUTES_PER_HOUR);
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input bit pinned, input out_word_t want);
    out_word_t st;
    while ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= w;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    advance_sequencer(w, st);
    pending_status.push_back(pinned ? want : st);
    words_sent++;
  endtask

  task automatic add_row(input in_word_t w, input bit pinned, input out_word_t want);
    drill_row_t r;
    r.stim   = w;
    r.pinned = pinned;
    r.want   = want;
    drill.push_back(r);
  endtask

  task automatic run_phase(input int count);
    int stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 5)) send_word(rand_word(), 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 8)) send_word(line_word(), 1'b0, '0);
        send_word(cmd_word(CMD_START), 1'b0, '0);
        repeat ($urandom_range(10, 60)) begin
          case ($urandom_range(39))
            0:       send_word(cmd_word(CMD_STOP), 1'b0, '0);
            1:       send_word(cmd_word(CMD_START), 1'b0, '0);
            2, 3:    send_word(line_word(), 1'b0, '0);
            default: send_word(tick_word(), 1'b0, '0);
          endcase
        end
        if ($urandom_range(1) == 1) send_word(cmd_word(CMD_STOP), 1'b0, '0);
      end
    end
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    if (errors <= 40) begin
      $display("mismatch on %s at result %0d: got %0h, want %0h", field, results_seen, got,
               want);
    end
  endtask

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    out_word_t want;
    out_word_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      results_seen++;
      if (got.finished === 1'b1) runs_finished++;
      if (pending_status.size() == 0) begin
        flag_mismatch("unexpected word", 32'(got), '0);
      end else begin
        want = pending_status.pop_front();
        if (got.tone_on !== want.tone_on) begin
          flag_mismatch("tone_on", 32'(got.tone_on), 32'(want.tone_on));
        end
        if (got.dac_level !== want.dac_level) begin
          flag_mismatch("dac_level", 32'(got.dac_level), 32'(want.dac_level));
        end
        if (got.current_line !== want.current_line) begin
          flag_mismatch("current_line", 32'(got.current_line), 32'(want.current_line));
        end
        if (got.running !== want.running) begin
          flag_mismatch("running", 32'(got.running), 32'(want.running));
        end
        if (got.finished !== want.finished) begin
          flag_mismatch("finished", 32'(got.finished), 32'(want.finished));
        end
      end
    end
  end

  initial begin
    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.data    = '0;
    result_ch.ready = 1'b0;
    wall_ms         = '0;
    src_idle_pct    = 28;
    snk_idle_pct    = 47;

    add_row(pack_word(CMD_TICK, 4'd15, OP_SPARE, 16'hFFFF, 32'hFFFF_FFFF, 5'd23, 6'd59, 4'hF),
            1'b1, '0);
    add_row(pack_word(CMD_WRITE, 4'd0, OP_DAC, 16'd509, '0, '0, '0, '0), 1'b1, '0);
    add_row(pack_word(CMD_WRITE, 4'd1, OP_BEEP, 16'd600, '0, '0, '0, '0), 1'b1, '0);
    add_row(pack_word(CMD_WRITE, 4'd2, OP_WAIT_TICKS, 16'd1201, '0, '0, '0, '0), 1'b1, '0);
    add_row(pack_word(CMD_WRITE, 4'd3, OP_WAIT_TIME, 16'd2879, '0, '0, '0, '0), 1'b1, '0);
    add_row(pack_word(CMD_WRITE, 4'd4, OP_WAIT_BUTTON, 16'd7, '0, '0, '0, '0), 1'b1, '0);
    add_row(pack_word(CMD_WRITE, 4'd5, OP_SPARE, 16'hFFFF, '0, '0, '0, '0), 1'b1, '0);
    add_row(pack_word(CMD_START, '0, '0, '0, '0, '0, '0, '0), 1'b1,
            '{1'b0, 8'd0, 4'd0, 1'b1, 1'b0});
    add_row(pack_word(CMD_TICK, '0, '0, '0, 32'd77, '0, '0, '0), 1'b1,
            '{1'b0, 8'd254, 4'd1, 1'b1, 1'b0});
    add_row(pack_word(CMD_TICK, '0, '0, '0, 32'd0, '0, '0, '0), 1'b0, '0);
    add_row(pack_word(CMD_TICK, '0, '0, '0, 32'hFFFF_FFFF, '0, '0, '0), 1'b0, '0);
    add_row(pack_word(CMD_TICK, '0, '0, '0, 32'hFFFF_FFFF, '0, '0, '0), 1'b0, '0);
    add_row(pack_word(CMD_TICK, '0, '0, '0, 32'd0, '0, '0, '0), 1'b0, '0);
    add_row(pack_word(CMD_TICK, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(pack_word(CMD_TICK, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(pack_word(CMD_TICK, '0, '0, '0, '0, 5'd23, 6'd58, '0), 1'b0, '0);
    add_row(pack_word(CMD_TICK, '0, '0, '0, '0, 5'd23, 6'd59, '0), 1'b0, '0);
    add_row(pack_word(CMD_TICK, '0, '0, '0, '0, '0, '0, 4'd7), 1'b0, '0);
    add_row(pack_word(CMD_TICK, '0, '0, '0, '0, '0, '0, 4'd8), 1'b0, '0);
    add_row(pack_word(CMD_TICK, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(pack_word(CMD_WRITE, 4'd7, OP_RESTART, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(pack_word(CMD_TICK, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(pack_word(CMD_TICK, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(pack_word(CMD_START, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(pack_word(CMD_TICK, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(pack_word(CMD_STOP, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (drill[i]) send_word(drill[i].stim, drill[i].pinned, drill[i].want);

    run_phase(645);
    src_idle_pct = 47;
    snk_idle_pct = 28;
    run_phase(640);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_phase(640);

    item_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d words over three idle mixes; %0d results checked, %0d runs completed.",
             words_sent, results_seen, runs_finished);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
